// ===== rtl/core/quaternion_to_euler_angles_core_assert.svh =====
// Assertion macros shared by the checker of the quaternion to Euler core.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_ASSERT_SVH

// Check that pre implies post in the same cycle, outside reset
`define QTE_ASSERT_NOW(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Check that pre implies post in the next cycle, outside reset
`define QTE_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

// Check that pre implies post in the next cycle, reset included
`define QTE_ASSERT_ALWAYS_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/qte_pkg.sv =====
// Shared widths, constants, types and rounding helpers of the quaternion to Euler core.
// No dependencies; the front end, square root, CORDIC and top level import this package.
`default_nettype none

package qte_pkg;

   localparam int FRAC_BITS    = 14;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_RUN   = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

   localparam int PROD_FRAC = 28;
   localparam int ANG_FRAC  = 20;
   localparam int THR_FRAC  = 14;

   localparam int IN_W    = 16;
   localparam int PROD_W  = 2 * IN_W;
   localparam int SUM_W   = PROD_W + 2;
   localparam int SPC_W   = PROD_FRAC + 2;
   localparam int LP_W    = SPC_W + 14;
   localparam int RAD_W   = 2 * PROD_FRAC + 1;
   localparam int ROOT_STEPS = PROD_FRAC + 1;
   localparam int ROOT_W  = PROD_FRAC + 1;
   localparam int DSH     = PROD_FRAC - FRAC_BITS;
   localparam int DP_W    = FRAC_BITS + 7;
   localparam int ANG_W   = ANG_FRAC + 10;
   localparam int OSH     = ANG_FRAC - 6;
   localparam int RA_W    = ANG_W - OSH + 1;

   localparam int THR_W   = 15;
   localparam int PITCH_W = 14;
   localparam int YAW_W   = 15;
   localparam int ROLL_W  = 15;

   localparam int PITCH_LIM = 5760;
   localparam int YAW_LIM   = 11520;
   localparam int THR_RESET = 16382;

   localparam longint HALF_DP = (DSH > 0) ? (64'sd1 <<< (DSH - 1)) : 64'sd0;
   localparam longint HALF_OUT = 64'sd1 <<< (OSH - 1);

   // arctan(2^-i) in degrees times 2^20
   localparam int ATAN_TAB [32] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7,
      4, 2, 1, 0, 0, 0, 0, 0
   };

   // Operands of the three angle units, already in datapath format
   typedef struct packed {
      logic                     lock;
      logic signed [PITCH_W-1:0] lockp;
      logic signed [DP_W-1:0]   pitch_y;
      logic signed [DP_W-1:0]   yaw_y;
      logic signed [DP_W-1:0]   yaw_x;
      logic signed [DP_W-1:0]   roll_y;
      logic signed [DP_W-1:0]   roll_x;
   } qte_side_type;

   typedef struct packed {
      qte_side_type       side;
      logic [RAD_W-1:0]   rad;
   } qte_front_type;

   typedef struct packed {
      logic signed [DP_W-1:0]  x;
      logic signed [DP_W-1:0]  y;
      logic signed [ANG_W-1:0] z;
      logic                    zero;
   } qte_lane_type;

   typedef struct packed {
      logic                      lock;
      logic signed [PITCH_W-1:0] lockp;
   } qte_tag_type;

   typedef struct packed {
      logic signed [PITCH_W-1:0] pitch;
      logic signed [YAW_W-1:0]   yaw;
      logic signed [ROLL_W-1:0]  roll;
      logic                      lock;
   } qte_result_type;

   // Q28 value to datapath format, rounding half away from zero
   function automatic logic signed [DP_W-1:0] to_dp(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0]                  mag;
      logic [SUM_W-1:0]                  rnd;
      logic signed [SUM_W+FRAC_BITS:0]   wide;
      mag  = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
      rnd  = (mag + SUM_W'(HALF_DP)) >> DSH;
      wide = (SUM_W + FRAC_BITS + 1)'(v) <<< (-DSH);
      if (DSH > 0) begin
         to_dp = v[SUM_W-1] ? $signed(-DP_W'(rnd)) : $signed(DP_W'(rnd));
      end else begin
         to_dp = DP_W'(wide);
      end
   endfunction

   // Angle accumulator to degrees times 64, rounding half away from zero
   function automatic logic signed [RA_W-1:0] rnd_ang(input logic signed [ANG_W-1:0] z);
      logic [ANG_W-1:0] mag;
      logic [ANG_W-1:0] rnd;
      mag = z[ANG_W-1] ? ANG_W'(-z) : ANG_W'(z);
      rnd = (mag + ANG_W'(HALF_OUT)) >> OSH;
      rnd_ang = z[ANG_W-1] ? $signed(-RA_W'(rnd)) : $signed(RA_W'(rnd));
   endfunction

   function automatic logic signed [RA_W-1:0] clamp_ang(input logic signed [RA_W-1:0] v,
                                                        input int lim);
      logic signed [RA_W-1:0] hi;
      hi = RA_W'(lim);
      if (v > hi) begin
         clamp_ang = hi;
      end else if (v < -hi) begin
         clamp_ang = -hi;
      end else begin
         clamp_ang = v;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/qte_front.sv =====
// Front end of the quaternion to Euler core: products, pitch sine, lock test,
// operand selection and the radicand of the pitch cosine. Uses qte_pkg.
`default_nettype none

module qte_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [qte_pkg::THR_W-1:0]         csr_wdata,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [qte_pkg::IN_W-1:0]   quat_w,
   input  logic signed [qte_pkg::IN_W-1:0]   quat_x,
   input  logic signed [qte_pkg::IN_W-1:0]   quat_y,
   input  logic signed [qte_pkg::IN_W-1:0]   quat_z,
   output logic                              out_valid,
   input  logic                              out_ready,
   output qte_pkg::qte_front_type            out_data
);
   import qte_pkg::*;

   localparam logic signed [SUM_W-1:0] ONE_Q  = SUM_W'(64'sd1 <<< PROD_FRAC);
   localparam logic signed [SUM_W-1:0] HALF_Q = SUM_W'(64'sd1 <<< (PROD_FRAC - 1));
   localparam logic [RAD_W-1:0]        RAD_ONE = RAD_W'(64'd1 << (2 * PROD_FRAC));
   localparam logic [LP_W-1:0]         LP_HALF = LP_W'(64'd1 << (PROD_FRAC - 1));

   logic [THR_W-1:0] thr_ff;
   logic             valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic             rdy1, rdy2, rdy3, rdy4;

   logic signed [PROD_W-1:0] wx_ff, yz_ff, wy_ff, xz_ff, xx_ff, yy_ff, zz_ff, xy_ff, wz_ff;

   logic                     lock2_ff, lock2_in;
   logic signed [SPC_W-1:0]  spc2_ff, spc2_in;
   logic signed [SUM_W-1:0]  yaw_y2_ff, yaw_x2_ff, roll_y2_ff, roll_x2_ff;
   logic signed [SUM_W-1:0]  yaw_y2_in, yaw_x2_in, roll_y2_in, roll_x2_in;

   logic                     lock3_ff;
   logic [RAD_W-1:0]         sq3_ff, sq3_in;
   logic signed [LP_W-1:0]   lp3_ff, lp3_in;
   logic signed [DP_W-1:0]   py3_ff, yy3_ff, yx3_ff, ry3_ff, rx3_ff;

   qte_front_type            out_ff, out_in;

   logic signed [SUM_W-1:0]  sp;
   logic [SUM_W-1:0]         spa;
   logic [SUM_W-1:0]         thr_ext;
   logic signed [2*SPC_W-1:0] sq_full;
   logic [LP_W-1:0]          lp_mag, lp_rnd;

   // Lock threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(THR_RESET);
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   // Ready chain: a stage moves when it is empty or the next one moves
   assign rdy4     = !valid4_ff || out_ready;
   assign rdy3     = !valid3_ff || rdy4;
   assign rdy2     = !valid2_ff || rdy3;
   assign rdy1     = !valid1_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         if (rdy1) valid1_ff <= in_valid;
         if (rdy2) valid2_ff <= valid1_ff;
         if (rdy3) valid3_ff <= valid2_ff;
         if (rdy4) valid4_ff <= valid3_ff;
      end
   end

   // Stage 1: all quaternion products
   always_ff @(posedge clock) begin
      if (rdy1) begin
         wx_ff <= quat_w * quat_x;
         yz_ff <= quat_y * quat_z;
         wy_ff <= quat_w * quat_y;
         xz_ff <= quat_x * quat_z;
         xx_ff <= quat_x * quat_x;
         yy_ff <= quat_y * quat_y;
         zz_ff <= quat_z * quat_z;
         xy_ff <= quat_x * quat_y;
         wz_ff <= quat_w * quat_z;
      end
   end

   // Stage 2: pitch sine, lock test, clamp and angle operands
   always_comb begin
      sp       = (SUM_W'(wx_ff) - SUM_W'(yz_ff)) <<< 1;
      spa      = sp[SUM_W-1] ? SUM_W'(-sp) : SUM_W'(sp);
      thr_ext  = SUM_W'(thr_ff) << (PROD_FRAC - THR_FRAC);
      lock2_in = spa > thr_ext;
      if (sp > ONE_Q) begin
         spc2_in = SPC_W'(ONE_Q);
      end else if (sp < -ONE_Q) begin
         spc2_in = SPC_W'(-ONE_Q);
      end else begin
         spc2_in = SPC_W'(sp);
      end
      if (lock2_in) begin
         yaw_y2_in = SUM_W'(wy_ff) - SUM_W'(xz_ff);
         yaw_x2_in = HALF_Q - SUM_W'(yy_ff) - SUM_W'(zz_ff);
      end else begin
         yaw_y2_in = SUM_W'(xz_ff) + SUM_W'(wy_ff);
         yaw_x2_in = HALF_Q - SUM_W'(xx_ff) - SUM_W'(yy_ff);
      end
      roll_y2_in = SUM_W'(xy_ff) + SUM_W'(wz_ff);
      roll_x2_in = HALF_Q - SUM_W'(xx_ff) - SUM_W'(zz_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         lock2_ff   <= lock2_in;
         spc2_ff    <= spc2_in;
         yaw_y2_ff  <= yaw_y2_in;
         yaw_x2_ff  <= yaw_x2_in;
         roll_y2_ff <= roll_y2_in;
         roll_x2_ff <= roll_x2_in;
      end
   end

   // Stage 3: square and lock pitch product, convert operands
   always_comb begin
      sq_full = spc2_ff * spc2_ff;
      sq3_in  = RAD_W'(sq_full);
      lp3_in  = LP_W'(spc2_ff) * LP_W'(PITCH_LIM);
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         lock3_ff <= lock2_ff;
         sq3_ff   <= sq3_in;
         lp3_ff   <= lp3_in;
         py3_ff   <= to_dp(SUM_W'(spc2_ff));
         yy3_ff   <= to_dp(yaw_y2_ff);
         yx3_ff   <= to_dp(yaw_x2_ff);
         ry3_ff   <= to_dp(roll_y2_ff);
         rx3_ff   <= to_dp(roll_x2_ff);
      end
   end

   // Stage 4: radicand of the cosine and rounded lock pitch
   // The clamped sine keeps the lock pitch inside its range.
   always_comb begin
      lp_mag = lp3_ff[LP_W-1] ? LP_W'(-lp3_ff) : LP_W'(lp3_ff);
      lp_rnd = (lp_mag + LP_HALF) >> PROD_FRAC;
      out_in.rad          = RAD_ONE - sq3_ff;
      out_in.side.lock    = lock3_ff;
      out_in.side.lockp   = lp3_ff[LP_W-1] ? $signed(-PITCH_W'(lp_rnd))
                                           : $signed(PITCH_W'(lp_rnd));
      out_in.side.pitch_y = py3_ff;
      out_in.side.yaw_y   = yy3_ff;
      out_in.side.yaw_x   = yx3_ff;
      out_in.side.roll_y  = ry3_ff;
      out_in.side.roll_x  = rx3_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = valid4_ff;
   assign out_data  = out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/qte_isqrt.sv =====
// Pipelined integer square root of the pitch cosine radicand, one root bit per stage.
// Carries the angle operands alongside. Uses qte_pkg.
`default_nettype none

module qte_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  qte_pkg::qte_front_type       in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [qte_pkg::ROOT_W-1:0]   out_root,
   output qte_pkg::qte_side_type        out_side
);
   import qte_pkg::*;

   logic [ROOT_STEPS-1:0] valid_ff;
   logic [ROOT_STEPS:0]   rdy;
   logic [RAD_W-1:0]      n_ff   [ROOT_STEPS];
   logic [RAD_W-1:0]      r_ff   [ROOT_STEPS];
   qte_side_type          side_ff[ROOT_STEPS];
   logic [RAD_W-1:0]      n_in   [ROOT_STEPS];
   logic [RAD_W-1:0]      r_in   [ROOT_STEPS];
   logic [RAD_W-1:0]      n_src  [ROOT_STEPS];
   logic [RAD_W-1:0]      r_src  [ROOT_STEPS];
   qte_side_type          side_src[ROOT_STEPS];
   logic [ROOT_STEPS-1:0] valid_src;

   // Ready chain from the output back to the input
   always_comb begin
      rdy[ROOT_STEPS] = out_ready;
      for (int k = ROOT_STEPS - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   // Stage inputs
   always_comb begin
      n_src[0]    = in_data.rad;
      r_src[0]    = '0;
      side_src[0] = in_data.side;
      valid_src   = {valid_ff[ROOT_STEPS-2:0], in_valid};
      for (int k = 1; k < ROOT_STEPS; k++) begin
         n_src[k]    = n_ff[k-1];
         r_src[k]    = r_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
   end

   // One restoring step per stage, test bit falling by two each stage
   always_comb begin
      for (int k = 0; k < ROOT_STEPS; k++) begin
         logic [RAD_W:0]   trial;
         logic [RAD_W-1:0] bit_k;
         bit_k = RAD_W'(1) << (2 * (ROOT_STEPS - 1 - k));
         trial = {1'b0, r_src[k]} + {1'b0, bit_k};
         if ({1'b0, n_src[k]} >= trial) begin
            n_in[k] = n_src[k] - RAD_W'(trial);
            r_in[k] = (r_src[k] >> 1) + bit_k;
         end else begin
            n_in[k] = n_src[k];
            r_in[k] = r_src[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < ROOT_STEPS; k++) begin
            if (rdy[k]) valid_ff[k] <= valid_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ROOT_STEPS; k++) begin
         if (rdy[k]) begin
            n_ff[k]    <= n_in[k];
            r_ff[k]    <= r_in[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_STEPS-1];
   assign out_root  = ROOT_W'(r_ff[ROOT_STEPS-1]);
   assign out_side  = side_ff[ROOT_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/core/qte_cordic.sv =====
// Three-lane pipelined vectoring CORDIC (pitch, yaw, roll) with the final rounding,
// clamping and lock selection in the output register. Uses qte_pkg.
`default_nettype none

module qte_cordic (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [qte_pkg::ROOT_W-1:0]  in_root,
   input  qte_pkg::qte_side_type       in_side,
   output logic                        out_valid,
   input  logic                        out_ready,
   output qte_pkg::qte_result_type     out_data
);
   import qte_pkg::*;

   localparam int NLANE = 3;
   localparam int LAST  = CORDIC_RUN + 1;
   localparam logic signed [ANG_W-1:0] ANG_TURN_HALF = ANG_W'(64'sd180 <<< ANG_FRAC);

   logic [LAST:0]   valid_ff;
   logic [LAST+1:0] rdy;
   logic [LAST:0]   valid_src;

   qte_lane_type    lane_ff [CORDIC_RUN+1][NLANE];
   qte_lane_type    lane_in [CORDIC_RUN+1][NLANE];
   qte_tag_type     tag_ff  [CORDIC_RUN+1];
   qte_tag_type     tag_src [CORDIC_RUN+1];
   qte_result_type  out_ff, out_in;

   logic signed [DP_W-1:0] pre_x [NLANE];
   logic signed [DP_W-1:0] pre_y [NLANE];
   logic signed [RA_W-1:0] ang   [NLANE];

   // Ready chain from the output back to the input
   always_comb begin
      rdy[LAST+1] = out_ready;
      for (int k = LAST; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end
   assign in_ready  = rdy[0];
   assign valid_src = {valid_ff[LAST-1:0], in_valid};

   always_comb begin
      // Pre-rotation: fold the left half plane and flag a null vector
      pre_y[0] = in_side.pitch_y;
      pre_x[0] = to_dp($signed({{(SUM_W-ROOT_W){1'b0}}, in_root}));
      pre_y[1] = in_side.yaw_y;
      pre_x[1] = in_side.yaw_x;
      pre_y[2] = in_side.roll_y;
      pre_x[2] = in_side.roll_x;
      tag_src[0].lock  = in_side.lock;
      tag_src[0].lockp = in_side.lockp;
      for (int l = 0; l < NLANE; l++) begin
         lane_in[0][l].zero = (pre_x[l] == '0) && (pre_y[l] == '0);
         if (pre_x[l][DP_W-1]) begin
            lane_in[0][l].x = -pre_x[l];
            lane_in[0][l].y = -pre_y[l];
            lane_in[0][l].z = pre_y[l][DP_W-1] ? -ANG_TURN_HALF : ANG_TURN_HALF;
         end else begin
            lane_in[0][l].x = pre_x[l];
            lane_in[0][l].y = pre_y[l];
            lane_in[0][l].z = '0;
         end
      end

      // One micro-rotation per stage, driving y toward zero
      for (int i = 1; i <= CORDIC_RUN; i++) begin
         tag_src[i] = tag_ff[i-1];
         for (int l = 0; l < NLANE; l++) begin
            lane_in[i][l].zero = lane_ff[i-1][l].zero;
            if (lane_ff[i-1][l].y[DP_W-1]) begin
               lane_in[i][l].x = lane_ff[i-1][l].x - (lane_ff[i-1][l].y >>> (i - 1));
               lane_in[i][l].y = lane_ff[i-1][l].y + (lane_ff[i-1][l].x >>> (i - 1));
               lane_in[i][l].z = lane_ff[i-1][l].z - ANG_W'(ATAN_TAB[i-1]);
            end else begin
               lane_in[i][l].x = lane_ff[i-1][l].x + (lane_ff[i-1][l].y >>> (i - 1));
               lane_in[i][l].y = lane_ff[i-1][l].y - (lane_ff[i-1][l].x >>> (i - 1));
               lane_in[i][l].z = lane_ff[i-1][l].z + ANG_W'(ATAN_TAB[i-1]);
            end
         end
      end
   end

   // Output: round, clamp, zero a null vector, apply the lock overrides
   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         if (lane_ff[CORDIC_RUN][l].zero) begin
            ang[l] = '0;
         end else begin
            ang[l] = clamp_ang(rnd_ang(lane_ff[CORDIC_RUN][l].z),
                               (l == 0) ? PITCH_LIM : YAW_LIM);
         end
      end
      out_in.lock  = tag_ff[CORDIC_RUN].lock;
      out_in.pitch = tag_ff[CORDIC_RUN].lock ? tag_ff[CORDIC_RUN].lockp : PITCH_W'(ang[0]);
      out_in.yaw   = YAW_W'(ang[1]);
      out_in.roll  = tag_ff[CORDIC_RUN].lock ? '0 : ROLL_W'(ang[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k <= LAST; k++) begin
            if (rdy[k]) valid_ff[k] <= valid_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= CORDIC_RUN; i++) begin
         if (rdy[i]) begin
            tag_ff[i] <= tag_src[i];
            for (int l = 0; l < NLANE; l++) begin
               lane_ff[i][l] <= lane_in[i][l];
            end
         end
      end
      if (rdy[LAST]) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = valid_ff[LAST];
   assign out_data  = out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/quaternion_to_euler_angles_core.sv =====
// Quaternion to Euler angles: a pipeline of 4 front-end stages, 29 square-root
// stages and 18 CORDIC stages incl. pre-rotation and output.
// Throughput one request per cycle; each stage stalls only when full and blocked.
// Synchronous active-high reset empties the pipeline and sets lock_threshold to 16382.
// Depends on qte_pkg, qte_front, qte_isqrt and qte_cordic.
`default_nettype none

module quaternion_to_euler_angles_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [qte_pkg::THR_W-1:0]    csr_wdata,   // lock_threshold
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [63:0]                  req_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [47:0]                  rsp_tdata,   // pitch_deg, yaw_deg, roll_deg, zero fill
   output logic                         rsp_tuser    // gimbal_lock
);
   import qte_pkg::*;

   logic           fr_valid, fr_ready;
   qte_front_type  fr_data;
   logic           sq_valid, sq_ready;
   logic [ROOT_W-1:0] sq_root;
   qte_side_type   sq_side;
   qte_result_type res;

   // Split the request into the four quaternion components
   qte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .quat_w    ($signed(req_tdata[15:0])),
      .quat_x    ($signed(req_tdata[31:16])),
      .quat_y    ($signed(req_tdata[47:32])),
      .quat_z    ($signed(req_tdata[63:48])),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_data  (fr_data)
   );

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   (fr_data),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   qte_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_ready  (sq_ready),
      .in_root   (sq_root),
      .in_side   (sq_side),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   // Pack the result fields, lowest field first
   assign rsp_tdata = {4'b0000, res.roll, res.yaw, res.pitch};
   assign rsp_tuser = res.lock;

endmodule

`default_nettype wire

// ===== rtl/core/qte_checker.sv =====
// Port-level checker for the quaternion to Euler core and its bind to the top level.
// Depends on quaternion_to_euler_angles_core_assert.svh.
`default_nettype none

`include "quaternion_to_euler_angles_core_assert.svh"

module qte_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [14:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        rsp_tuser
);

   // Hold a stalled result
   `QTE_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // Drop roll under gimbal lock
   `QTE_ASSERT_NOW(a_lock_roll, rsp_tvalid && rsp_tuser, rsp_tdata[43:29] == 15'd0, "roll not zero under lock")

   // Keep pitch inside its range
   `QTE_ASSERT_NOW(a_pitch_range, rsp_tvalid, ($signed(rsp_tdata[13:0]) <= 14'sd5760) && ($signed(rsp_tdata[13:0]) >= -14'sd5760), "pitch out of range")

   // Empty the pipeline on reset
   `QTE_ASSERT_ALWAYS_NEXT(a_reset_empty, reset, !rsp_tvalid, "result valid after reset")

endmodule

bind quaternion_to_euler_angles_core qte_checker u_qte_checker (.*);

`default_nettype wire
